@@ rtl/arpcr_pkg.sv @@
// arpcr_pkg: shared types and codes for the arp cache resolver
// no dependencies; imported by every module of the block
package arpcr_pkg;

  localparam logic [2:0] ACT_IDLE    = 3'd0;
  localparam logic [2:0] ACT_SEND    = 3'd1;
  localparam logic [2:0] ACT_HOLD    = 3'd2;
  localparam logic [2:0] ACT_REQUEST = 3'd3;
  localparam logic [2:0] ACT_REPLY   = 3'd4;
  localparam logic [2:0] ACT_RELEASE = 3'd5;
  localparam logic [2:0] ACT_DISCARD = 3'd6;
  localparam logic [2:0] ACT_ERROR   = 3'd7;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_PROTO  = 2'd1;
  localparam logic [1:0] ERR_SUBNET = 2'd2;

  localparam logic [1:0] FUNC_RESOLVE = 2'd0;
  localparam logic [1:0] FUNC_ARP     = 2'd1;
  localparam logic [1:0] FUNC_TICK    = 2'd2;

  localparam logic [2:0] REG_LOCAL_IP      = 3'd0;
  localparam logic [2:0] REG_NET_MASK      = 3'd1;
  localparam logic [2:0] REG_GATEWAY_IP    = 3'd2;
  localparam logic [2:0] REG_LOCAL_MAC     = 3'd3;
  localparam logic [2:0] REG_QUERY_DELAY   = 3'd4;
  localparam logic [2:0] REG_RETRY_LIMIT   = 3'd5;
  localparam logic [2:0] REG_ENTRY_TIMEOUT = 3'd6;
  localparam logic [2:0] REG_SWEEP_PERIOD  = 3'd7;

  localparam logic [15:0] OPC_REQUEST = 16'd1;
  localparam logic [15:0] OPC_REPLY   = 16'd2;
  localparam logic [15:0] HW_ETHERNET = 16'd1;
  localparam logic [15:0] PROTO_IPV4  = 16'h0800;

  localparam logic [47:0] BCAST_MAC   = 48'hFFFF_FFFF_FFFF;
  localparam logic [3:0]  RETRY_MAX   = 4'hF;
  localparam logic [15:0] USE_MAX     = 16'hFFFF;
  localparam logic [4:0]  MAX_RESULTS = 5'd16;

  typedef struct packed {
    logic [31:0] local_ip;
    logic [31:0] net_mask;
    logic [31:0] gateway_ip;
    logic [47:0] local_mac;
    logic [15:0] query_delay;
    logic [3:0]  retry_limit;
    logic [15:0] entry_timeout;
    logic [15:0] sweep_period;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [1:0]  error_kind;
    logic [47:0] mac;
    logic [31:0] ip;
  } res_t;

  typedef enum logic [1:0] {CMD_RESOLVE, CMD_LEARN, CMD_TICK, CMD_SINGLE} cmd_kind_t;

  // resolve: res.ip is the next hop; learn: res.ip/mac are the sender
  typedef struct packed {
    cmd_kind_t kind;
    res_t      res;
  } cmd_t;

  typedef struct packed {
    logic        valid;
    logic        fin;
    res_t        res;
  } emit_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] expires;
    logic [15:0] use_count;
    logic [31:0] query_time;
    logic [3:0]  retries;
  } entry_t;

  typedef enum logic [3:0] {
    B_IDLE, B_FIND, B_EVICT, B_INIT, B_HIT, B_LEARN,
    B_QUERY, B_SINGLE, B_TICK, B_SWEEP, B_FIN
  } bstate_t;

endpackage

@@ rtl/arp_cache_resolver_core.sv @@
// arp_cache_resolver_core: top level of the arp cache resolver
// instantiates arpcr_front, arpcr_back and arpcr_outreg; uses arpcr_pkg
//
// usage: input transactions (func plus packet fields) are taken on
// in_valid when in_stall is low; result transactions leave on out_valid
// and are taken when out_stall is low. last marks the final result of a
// transaction; a tick with nothing to report gives no result at all.
// a two-entry command queue sits between the classifier and the table
// sequencer, so input keeps flowing while the sequencer works.
// the sequencer visits one slot a cycle as it scans the table, but a
// sweep pauses at a slot that sends a result until the output takes it.
// the first result is registered out as it leaves the pending stage.
// when out_stall is high the sequencer halts at its next result and the
// queue fills, then in_stall rises. reset clears the slot table valid
// bits, time, sweep countdown, queues and loads register defaults.
// configuration registers are written through cfg_we/cfg_index/cfg_data.
module arp_cache_resolver_core import arpcr_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [31:0] dest_ip,
  input  logic [15:0] arp_opcode,
  input  logic [15:0] arp_hw_type,
  input  logic [15:0] arp_proto_type,
  input  logic [31:0] sender_ip,
  input  logic [47:0] sender_mac,
  input  logic [31:0] target_ip,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  action,
  output logic [1:0]  error_kind,
  output logic [47:0] peer_mac,
  output logic [31:0] peer_ip,
  output logic        last
);

  cfg_t  cfg;
  logic  cmd_valid;
  cmd_t  cmd;
  logic  cmd_pop;
  emit_t em;
  logic  ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.local_ip      <= 32'd0;
      cfg.net_mask      <= 32'hFFFF_FF00;
      cfg.gateway_ip    <= 32'd0;
      cfg.local_mac     <= 48'd0;
      cfg.query_delay   <= 16'd1;
      cfg.retry_limit   <= 4'd5;
      cfg.entry_timeout <= 16'd600;
      cfg.sweep_period  <= 16'd60;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOCAL_IP:      cfg.local_ip      <= cfg_data[31:0];
        REG_NET_MASK:      cfg.net_mask      <= cfg_data[31:0];
        REG_GATEWAY_IP:    cfg.gateway_ip    <= cfg_data[31:0];
        REG_LOCAL_MAC:     cfg.local_mac     <= cfg_data;
        REG_QUERY_DELAY:   cfg.query_delay   <= cfg_data[15:0];
        REG_RETRY_LIMIT:   cfg.retry_limit   <= cfg_data[3:0];
        REG_ENTRY_TIMEOUT: cfg.entry_timeout <= cfg_data[15:0];
        REG_SWEEP_PERIOD:  cfg.sweep_period  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  arpcr_front u_front (
    .clk, .rst, .cfg, .in_valid, .in_stall, .func, .dest_ip, .arp_opcode,
    .arp_hw_type, .arp_proto_type, .sender_ip, .sender_mac, .target_ip,
    .cmd_valid, .cmd, .cmd_pop
  );

  arpcr_back #(.ENTRIES(ENTRIES)) u_back (
    .clk, .rst, .cfg, .cmd_valid, .cmd_head(cmd), .cmd_pop, .em, .ready
  );

  arpcr_outreg u_out (
    .clk, .rst, .em, .ready, .out_valid, .out_stall, .action, .error_kind,
    .peer_mac, .peer_ip, .last
  );

endmodule

@@ rtl/arpcr_front.sv @@
// arpcr_front: accepts input transactions, classifies them into commands
// and queues them for the back end; depends on arpcr_pkg
module arpcr_front import arpcr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [31:0] dest_ip,
  input  logic [15:0] arp_opcode,
  input  logic [15:0] arp_hw_type,
  input  logic [15:0] arp_proto_type,
  input  logic [31:0] sender_ip,
  input  logic [47:0] sender_mac,
  input  logic [31:0] target_ip,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_pop
);

  cmd_t       q [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  cmd_t       cmd_in;
  logic       push;
  logic [31:0] hop;

  assign hop = ((cfg.local_ip & cfg.net_mask) == (dest_ip & cfg.net_mask)) ?
               dest_ip : cfg.gateway_ip;

  always_comb begin
    cmd_in = '0;
    unique case (func)
      FUNC_RESOLVE: begin
        cmd_in.kind   = CMD_RESOLVE;
        cmd_in.res.ip = hop;
      end
      FUNC_ARP: begin
        cmd_in.kind = CMD_SINGLE;
        if (arp_hw_type != HW_ETHERNET || arp_proto_type != PROTO_IPV4 ||
            target_ip != cfg.local_ip ||
            (arp_opcode != OPC_REQUEST && arp_opcode != OPC_REPLY)) begin
          cmd_in.res.action     = ACT_ERROR;
          cmd_in.res.error_kind = ERR_PROTO;
        end else if (arp_opcode == OPC_REQUEST) begin
          cmd_in.res.action = ACT_REPLY;
          cmd_in.res.mac    = sender_mac;
          cmd_in.res.ip     = sender_ip;
        end else if ((sender_ip & cfg.net_mask) != (cfg.local_ip & cfg.net_mask)) begin
          cmd_in.res.action     = ACT_ERROR;
          cmd_in.res.error_kind = ERR_SUBNET;
        end else begin
          cmd_in.kind    = CMD_LEARN;
          cmd_in.res.mac = sender_mac;
          cmd_in.res.ip  = sender_ip;
        end
      end
      FUNC_TICK: cmd_in.kind = CMD_TICK;
      default: begin
        cmd_in.kind       = CMD_SINGLE;
        cmd_in.res.action = ACT_IDLE;
      end
    endcase
  end

  assign in_stall  = (count == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rp];

  always_ff @(posedge clk) begin
    if (push) q[wp] <= cmd_in;
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (cmd_pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, cmd_pop};
    end
  end

endmodule

@@ rtl/arpcr_back.sv @@
// arpcr_back: slot table and sequencer that carries out queued commands
// one slot visited per cycle unless a result stalls; depends on arpcr_pkg
module arpcr_back import arpcr_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  cmd_valid,
  input  cmd_t  cmd_head,
  output logic  cmd_pop,
  output emit_t em,
  input  logic  ready
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  entry_t      table_q [ENTRIES];
  logic [ENTRIES-1:0] slot_valid;
  logic [ENTRIES-1:0] slot_queried;

  bstate_t     state, state_next;
  logic [IW-1:0] idx, idx_next;
  cmd_t        cmd;
  logic        sweeping, sweeping_next;
  logic [4:0]  cnt;
  logic        free_found, free_found_next;
  logic [IW-1:0] free_idx, free_idx_next;
  logic        min_found, min_found_next;
  logic [IW-1:0] min_idx, min_idx_next;
  logic [31:0] min_exp, min_exp_next;
  logic [31:0] now_ticks;
  logic [15:0] sweep_countdown, countdown_next;

  entry_t ent, ent_wr;
  logic   v, qd;
  logic   ent_we, valid_we, valid_val, q_we, q_val;
  logic   want, fin, go, cnt_full;
  res_t   res;
  logic   fresh, stale, freeable, q_block, hit;
  logic   cur_free, cur_min;
  logic [3:0]  ret_inc;
  logic [47:0] mac_q;
  logic [15:0] cd_load;

  assign ent = table_q[idx];
  assign v   = slot_valid[idx];
  assign qd  = slot_queried[idx];

  assign fresh    = ent.expires > now_ticks;
  assign stale    = v && !fresh;
  assign freeable = (ent.retries > cfg.retry_limit) || (ent.use_count == 16'd0);
  assign q_block  = qd && (({1'b0, ent.query_time} + {17'd0, cfg.query_delay}) >
                           {1'b0, now_ticks});
  assign ret_inc  = (ent.retries == RETRY_MAX) ? RETRY_MAX : ent.retries + 4'd1;
  assign mac_q    = (ret_inc > cfg.retry_limit) ? BCAST_MAC : ent.mac;
  assign hit      = v && (ent.ip == cmd.res.ip);
  assign cur_free = !v;
  assign cur_min  = v && (!min_found || ent.expires < min_exp);
  assign cd_load  = (sweep_countdown != 16'd0) ? sweep_countdown :
                    (cfg.sweep_period == 16'd0) ? 16'd1 : cfg.sweep_period;
  assign cnt_full = (cnt >= MAX_RESULTS);

  // outputs and table writes
  always_comb begin
    want      = 1'b0;
    fin       = 1'b0;
    res       = '0;
    ent_we    = 1'b0;
    ent_wr    = ent;
    valid_we  = 1'b0;
    valid_val = 1'b0;
    q_we      = 1'b0;
    q_val     = 1'b0;
    unique case (state)
      B_EVICT: begin
        want = 1'b1;
        res  = '{action: ACT_DISCARD, error_kind: ERR_NONE, mac: ent.mac, ip: ent.ip};
      end
      B_INIT: begin
        ent_we    = 1'b1;
        ent_wr    = '{ip: cmd.res.ip, mac: BCAST_MAC, expires: 32'd0, use_count: 16'd1,
                      query_time: 32'd0, retries: 4'd0};
        valid_we  = 1'b1;
        valid_val = 1'b1;
        q_we      = 1'b1;
      end
      B_HIT: begin
        want = 1'b1;
        if (fresh) begin
          res    = '{action: ACT_SEND, error_kind: ERR_NONE, mac: ent.mac, ip: cmd.res.ip};
          ent_we = 1'b1;
          ent_wr.use_count = (ent.use_count == USE_MAX) ? USE_MAX : ent.use_count + 16'd1;
        end else begin
          res = '{action: ACT_HOLD, error_kind: ERR_NONE, mac: ent.mac, ip: cmd.res.ip};
        end
      end
      B_LEARN: begin
        want   = 1'b1;
        res    = '{action: ACT_RELEASE, error_kind: ERR_NONE, mac: cmd.res.mac,
                   ip: cmd.res.ip};
        ent_we = 1'b1;
        ent_wr.mac       = cmd.res.mac;
        ent_wr.expires   = now_ticks + {16'd0, cfg.entry_timeout};
        ent_wr.retries   = 4'd0;
        ent_wr.use_count = 16'd0;
      end
      B_QUERY: begin
        if (!q_block) begin
          want   = 1'b1;
          res    = '{action: ACT_REQUEST, error_kind: ERR_NONE, mac: mac_q, ip: ent.ip};
          ent_we = 1'b1;
          ent_wr.query_time = now_ticks;
          ent_wr.retries    = ret_inc;
          ent_wr.mac        = mac_q;
          q_we  = 1'b1;
          q_val = 1'b1;
        end
      end
      B_SINGLE: begin
        want = 1'b1;
        res  = cmd.res;
      end
      B_SWEEP: begin
        if (stale && freeable) begin
          want = 1'b1;
          res  = '{action: ACT_DISCARD, error_kind: ERR_NONE, mac: ent.mac, ip: ent.ip};
          valid_we = 1'b1;
          q_we     = 1'b1;
        end
      end
      B_FIN: fin = 1'b1;
      default: ;
    endcase
    go       = (want || fin) ? ((want && cnt_full) || ready) : 1'b1;
    em.valid = want && !cnt_full;
    em.fin   = fin;
    em.res   = res;
  end

  // next state
  always_comb begin
    state_next      = state;
    idx_next        = idx;
    sweeping_next   = sweeping;
    free_found_next = free_found;
    free_idx_next   = free_idx;
    min_found_next  = min_found;
    min_idx_next    = min_idx;
    min_exp_next    = min_exp;
    countdown_next  = sweep_countdown;
    cmd_pop         = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (cmd_valid) begin
          cmd_pop         = 1'b1;
          idx_next        = '0;
          sweeping_next   = 1'b0;
          free_found_next = 1'b0;
          min_found_next  = 1'b0;
          unique case (cmd_head.kind)
            CMD_RESOLVE, CMD_LEARN: state_next = B_FIND;
            CMD_TICK:               state_next = B_TICK;
            default:                state_next = B_SINGLE;
          endcase
        end
      end
      B_FIND: begin
        if (hit) begin
          state_next = (cmd.kind == CMD_RESOLVE) ? B_HIT : B_LEARN;
        end else if (idx == LAST) begin
          if (free_found || cur_free) begin
            idx_next   = free_found ? free_idx : idx;
            state_next = B_INIT;
          end else begin
            idx_next   = cur_min ? idx : min_idx;
            state_next = B_EVICT;
          end
        end else begin
          idx_next = idx + 1'b1;
          if (cur_free && !free_found) begin
            free_found_next = 1'b1;
            free_idx_next   = idx;
          end
          if (cur_min) begin
            min_found_next = 1'b1;
            min_idx_next   = idx;
            min_exp_next   = ent.expires;
          end
        end
      end
      B_EVICT: if (go) state_next = B_INIT;
      B_INIT:  state_next = (cmd.kind == CMD_RESOLVE) ? B_HIT : B_LEARN;
      B_HIT:   if (go) state_next = fresh ? B_FIN : B_QUERY;
      B_LEARN, B_SINGLE: if (go) state_next = B_FIN;
      B_QUERY: begin
        if (go) begin
          if (!sweeping) state_next = B_FIN;
          else if (idx == LAST) state_next = B_FIN;
          else begin
            idx_next   = idx + 1'b1;
            state_next = B_SWEEP;
          end
        end
      end
      B_TICK: begin
        countdown_next = cd_load - 16'd1;
        if (cd_load == 16'd1) begin
          idx_next      = '0;
          sweeping_next = 1'b1;
          state_next    = B_SWEEP;
        end else begin
          state_next = B_FIN;
        end
      end
      B_SWEEP: begin
        if (stale && !freeable) state_next = B_QUERY;
        else if (go) begin
          if (idx == LAST) state_next = B_FIN;
          else idx_next = idx + 1'b1;
        end
      end
      B_FIN: if (go) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) cmd <= cmd_head;
    idx      <= idx_next;
    free_idx <= free_idx_next;
    min_idx  <= min_idx_next;
    min_exp  <= min_exp_next;
    if (ent_we && go) table_q[idx] <= ent_wr;
    if (rst) begin
      state           <= B_IDLE;
      sweeping        <= 1'b0;
      free_found      <= 1'b0;
      min_found       <= 1'b0;
      cnt             <= 5'd0;
      now_ticks       <= 32'd0;
      sweep_countdown <= 16'd0;
      slot_valid      <= '0;
      slot_queried    <= '0;
    end else begin
      state           <= state_next;
      sweeping        <= sweeping_next;
      free_found      <= free_found_next;
      min_found       <= min_found_next;
      sweep_countdown <= countdown_next;
      if (state == B_TICK) now_ticks <= now_ticks + 32'd1;
      if (cmd_pop) cnt <= 5'd0;
      else if (em.valid && ready) cnt <= cnt + 5'd1;
      if (valid_we && go) slot_valid[idx] <= valid_val;
      if (q_we && go) slot_queried[idx] <= q_val;
    end
  end

endmodule

@@ rtl/arpcr_outreg.sv @@
// arpcr_outreg: one-deep pending stage plus output register; marks the
// final result of each transaction; depends on arpcr_pkg
module arpcr_outreg import arpcr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  emit_t       em,
  output logic        ready,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  action,
  output logic [1:0]  error_kind,
  output logic [47:0] peer_mac,
  output logic [31:0] peer_ip,
  output logic        last
);

  res_t pend;
  logic pend_valid;
  logic out_free;

  assign out_free = !out_valid || !out_stall;
  assign ready    = (em.valid || em.fin) && (!pend_valid || out_free);

  always_ff @(posedge clk) begin
    if (ready && pend_valid) begin
      action     <= pend.action;
      error_kind <= pend.error_kind;
      peer_mac   <= pend.mac;
      peer_ip    <= pend.ip;
      last       <= em.fin;
    end
    if (ready && em.valid) pend <= em.res;
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (ready && pend_valid) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      if (ready) pend_valid <= em.valid;
    end
  end

endmodule

@@ rtl/arpcr_checker.sv @@
// arpcr_checker: port-level checks on the result channel of the resolver
// bound to arp_cache_resolver_core; uses arpcr_pkg
module arpcr_checker import arpcr_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  action,
  input logic [1:0]  error_kind,
  input logic [47:0] peer_mac,
  input logic [31:0] peer_ip,
  input logic        last
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_error_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && action == ACT_ERROR |->
      error_kind != ERR_NONE && peer_mac == 48'd0 && peer_ip == 32'd0 && last)
    else $error("malformed error result");

  a_kind_none: assert property (@(posedge clk) disable iff (rst)
    out_valid && action != ACT_ERROR |-> error_kind == ERR_NONE)
    else $error("error kind on non-error result");

  a_idle_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && action == ACT_IDLE |-> last && peer_mac == 48'd0 && peer_ip == 32'd0)
    else $error("malformed idle result");

endmodule

bind arp_cache_resolver_core arpcr_checker u_chk (.*);
